// ===== rtl/transaction_tag_pool_macros.svh =====
// Assertion macros for the transaction tag pool.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef TRANSACTION_TAG_POOL_MACROS_SVH
`define TRANSACTION_TAG_POOL_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define TTP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("transaction tag pool check failed");
// Next-cycle implication, disabled during reset.
`define TTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("transaction tag pool check failed");
`else
`define TTP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TTP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ttp_pkg.sv =====
// Shared types, codes and helpers for the transaction tag pool.
// No dependencies; used by every other RTL file of the block but the macro header.
`default_nettype none

package ttp_pkg;

   // Default number of tags in the pool.
   localparam int POOL_SIZE_DEF = 16;

   // Width of the tag field.
   localparam int TAG_W = 8;

   // Request kinds.
   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_FREE   = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [1:0] ST_NOT_OUT   = 2'd2;
   localparam logic [1:0] ST_WAIT      = 2'd3;

   // Access to the busy-mark memory.
   typedef struct packed {
      logic             rd;
      logic [TAG_W-1:0] rd_tag;
      logic             wr;
      logic [TAG_W-1:0] wr_tag;
      logic             wr_busy;
   } busy_op_type;

   // Access to the free-tag stack.
   typedef struct packed {
      logic             rd;
      logic             pop;
      logic             push;
      logic [TAG_W-1:0] push_tag;
   } stack_op_type;

   // Address width for a memory of the given depth, at least one bit.
   function automatic int addr_width(input int depth);
      int w;
      w = 1;
      while ((1 << w) < depth) begin
         w = w + 1;
      end
      return w;
   endfunction

   // Width of a counter that holds 0 up to the given value.
   function automatic int count_width(input int max_value);
      int w;
      w = 1;
      while ((1 << w) <= max_value) begin
         w = w + 1;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ttp_req_if.sv =====
// Request channel of the transaction tag pool: valid/ready plus request fields.
// Depends on ttp_pkg for the tag width.
`default_nettype none

interface ttp_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic                        wait_empty;
   logic [ttp_pkg::TAG_W-1:0]   tag;

   modport source (output valid, output kind, output wait_empty, output tag, input ready);
   modport sink   (input valid, input kind, input wait_empty, input tag, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttp_rsp_if.sv =====
// Response channel of the transaction tag pool: valid/ready plus result fields.
// Depends on ttp_pkg for the tag width.
`default_nettype none

interface ttp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [ttp_pkg::TAG_W-1:0]   granted_tag;
   logic                        found;
   logic                        all_idle;

   modport source (output valid, output status, output granted_tag, output found,
                   output all_idle, input ready);
   modport sink   (input valid, input status, input granted_tag, input found,
                   input all_idle, output ready);
endinterface

`default_nettype wire

// ===== rtl/ttp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on ttp_pkg for the address width helper.
`default_nettype none

module ttp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [ttp_pkg::addr_width(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [ttp_pkg::addr_width(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ttp_stack.sv =====
// Free-tag stack of the transaction tag pool: stack memory, fill count and
// a low-water mark standing in for the reset contents. Depends on ttp_pkg, ttp_ram.
`default_nettype none

module ttp_stack #(
   parameter int POOL_SIZE = ttp_pkg::POOL_SIZE_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire ttp_pkg::stack_op_type                       op,
   output logic [ttp_pkg::count_width(POOL_SIZE)-1:0]       count,
   output logic [ttp_pkg::TAG_W-1:0]                        top_tag
);

   localparam int AW = ttp_pkg::addr_width(POOL_SIZE);
   localparam int CW = ttp_pkg::count_width(POOL_SIZE);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] low_ff, low_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] count_dec;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [ttp_pkg::TAG_W-1:0] ram_rdata;
   logic [ttp_pkg::TAG_W-1:0] reset_tag;

   // Top entry sits one below the fill count.
   assign count_dec = count_ff - CW'(1);
   assign rd_idx_in = op.rd ? count_dec : rd_idx_ff;
   assign rd_addr   = count_dec[AW-1:0];
   assign wr_addr   = count_ff[AW-1:0];

   ttp_ram #(
      .WIDTH (ttp_pkg::TAG_W),
      .DEPTH (POOL_SIZE)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (op.push),
      .wr_addr (wr_addr),
      .wr_data (op.push_tag),
      .rd_en   (op.rd),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Entries below the lowest fill ever reached still hold their reset tag.
   assign reset_tag = ttp_pkg::TAG_W'(POOL_SIZE) - ttp_pkg::TAG_W'(rd_idx_ff);
   assign top_tag   = (low_ff <= rd_idx_ff) ? ram_rdata : reset_tag;

   // Fill count and low-water mark.
   always_comb begin
      count_in = count_ff;
      low_in   = low_ff;
      if (op.pop) begin
         count_in = count_dec;
         if (count_dec < low_ff) begin
            low_in = count_dec;
         end
      end else if (op.push) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(POOL_SIZE);
         low_ff   <= CW'(POOL_SIZE);
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
      end
      rd_idx_ff <= rd_idx_in;
   end

   assign count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/ttp_busy.sv =====
// Busy-mark memory of the transaction tag pool, one bit per tag, with a
// clearing pass after reset. Depends on ttp_pkg, ttp_ram.
`default_nettype none

module ttp_busy #(
   parameter int POOL_SIZE = ttp_pkg::POOL_SIZE_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ttp_pkg::busy_op_type   op,
   output logic                        busy,
   output logic                        clearing
);

   localparam int AW = ttp_pkg::addr_width(POOL_SIZE);

   logic                      clr_ff, clr_in;
   logic [AW-1:0]             clr_idx_ff, clr_idx_in;
   logic [ttp_pkg::TAG_W-1:0] rd_dec;
   logic [ttp_pkg::TAG_W-1:0] wr_dec;
   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic                      ram_wdata;

   // Tag t lives at entry t-1.
   assign rd_dec = op.rd_tag - ttp_pkg::TAG_W'(1);
   assign wr_dec = op.wr_tag - ttp_pkg::TAG_W'(1);

   // The clearing pass owns the write port until every mark is zero.
   assign ram_we    = clr_ff | op.wr;
   assign ram_waddr = clr_ff ? clr_idx_ff : wr_dec[AW-1:0];
   assign ram_wdata = clr_ff ? 1'b0 : op.wr_busy;

   ttp_ram #(
      .WIDTH (1),
      .DEPTH (POOL_SIZE)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (op.rd),
      .rd_addr (rd_dec[AW-1:0]),
      .rd_data (busy)
   );

   // Sweep counter for the clearing pass.
   always_comb begin
      clr_in     = clr_ff;
      clr_idx_in = clr_idx_ff;
      if (clr_ff) begin
         if (clr_idx_ff == AW'(POOL_SIZE - 1)) begin
            clr_in = 1'b0;
         end else begin
            clr_idx_in = clr_idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   assign clearing = clr_ff;

endmodule

`default_nettype wire

// ===== rtl/transaction_tag_pool.sv =====
// Top level of the transaction tag pool: request sequencer and response register.
// Depends on ttp_pkg, ttp_req_if, ttp_rsp_if, ttp_stack, ttp_busy and the macro header.
//
//   Channel   Direction  Contents
//   req_bus   in         kind, wait_empty, tag
//   rsp_bus   out        status, granted_tag, found, all_idle
//
// A transaction is accepted, its stack top and busy mark are read from the
// memories in the next cycle, and the result is then registered in the response
// register. A new transaction is not accepted while one is in flight, since the
// memory read comes ahead of the read-modify-write of the memories.
// After reset the busy-mark memory is swept to zero, entry by entry, with
// req_bus.ready low. A response held on rsp_bus blocks the next acceptance.
`default_nettype none
`include "transaction_tag_pool_macros.svh"

module transaction_tag_pool #(
   parameter int POOL_SIZE = ttp_pkg::POOL_SIZE_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ttp_req_if.sink     req_bus,
   ttp_rsp_if.source   rsp_bus
);

   localparam int CW = ttp_pkg::count_width(POOL_SIZE);

   // Request stage.
   logic                      pending_ff, pending_in;
   logic [1:0]                kind_ff, kind_in;
   logic                      wait_ff, wait_in;
   logic [ttp_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                      tag_ok_ff, tag_ok_in;
   logic                      req_accept;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                status_ff, status_in;
   logic [ttp_pkg::TAG_W-1:0] granted_ff, granted_in;
   logic                      found_ff, found_in;
   logic                      idle_ff, idle_in;

   // Memory side.
   ttp_pkg::stack_op_type     stack_op;
   ttp_pkg::busy_op_type      busy_op;
   logic [CW-1:0]             stack_count;
   logic [ttp_pkg::TAG_W-1:0] top_tag;
   logic                      busy_rd;
   logic                      clearing;
   logic                      busy_hit;
   logic                      pool_idle;
   logic                      ok_alloc;
   logic                      ok_free;

   // Accept only when the clearing pass is done, no transaction is in flight and the response slot frees up.
   assign req_bus.ready = !clearing && !pending_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign pending_in = req_accept;
   assign kind_in    = req_accept ? req_bus.kind : kind_ff;
   assign wait_in    = req_accept ? req_bus.wait_empty : wait_ff;
   assign tag_in     = req_accept ? req_bus.tag : tag_ff;
   assign tag_ok_in  = req_accept ? ((req_bus.tag != '0) &&
                                     (req_bus.tag <= ttp_pkg::TAG_W'(POOL_SIZE)))
                                  : tag_ok_ff;

   assign busy_hit  = tag_ok_ff && busy_rd;
   assign pool_idle = (stack_count == CW'(POOL_SIZE));

   // Decide the outcome once the memory data is back.
   always_comb begin
      status_in  = ttp_pkg::ST_OK;
      granted_in = '0;
      found_in   = 1'b0;
      ok_alloc   = 1'b0;
      ok_free    = 1'b0;
      unique case (kind_ff)
         ttp_pkg::KIND_ALLOC: begin
            priority if (wait_ff && !pool_idle) begin
               status_in = ttp_pkg::ST_WAIT;
            end else if (stack_count == '0) begin
               status_in = ttp_pkg::ST_EXHAUSTED;
            end else begin
               ok_alloc   = pending_ff;
               granted_in = top_tag;
            end
         end
         ttp_pkg::KIND_LOOKUP: begin
            if (busy_hit) begin
               found_in = 1'b1;
            end else begin
               status_in = ttp_pkg::ST_NOT_OUT;
            end
         end
         ttp_pkg::KIND_FREE: begin
            if (busy_hit && (stack_count < CW'(POOL_SIZE))) begin
               ok_free = pending_ff;
            end else begin
               status_in = ttp_pkg::ST_NOT_OUT;
            end
         end
         default: begin
            status_in = ttp_pkg::ST_OK;
         end
      endcase

      // Idle after this step.
      if (ok_free) begin
         idle_in = (stack_count == CW'(POOL_SIZE - 1));
      end else if (ok_alloc) begin
         idle_in = 1'b0;
      end else begin
         idle_in = pool_idle;
      end
   end

   // Memory accesses: reads on acceptance, writes when the outcome is known.
   always_comb begin
      stack_op.rd       = req_accept;
      stack_op.pop      = ok_alloc;
      stack_op.push     = ok_free;
      stack_op.push_tag = tag_ff;

      busy_op.rd        = req_accept;
      busy_op.rd_tag    = req_bus.tag;
      busy_op.wr        = ok_alloc || ok_free;
      busy_op.wr_tag    = ok_alloc ? top_tag : tag_ff;
      busy_op.wr_busy   = ok_alloc;
   end

   ttp_stack #(
      .POOL_SIZE (POOL_SIZE)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .op      (stack_op),
      .count   (stack_count),
      .top_tag (top_tag)
   );

   ttp_busy #(
      .POOL_SIZE (POOL_SIZE)
   ) u_busy (
      .clock    (clock),
      .reset    (reset),
      .op       (busy_op),
      .busy     (busy_rd),
      .clearing (clearing)
   );

   // Response register holds until taken.
   assign rsp_valid_in = pending_ff || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff   <= kind_in;
      wait_ff   <= wait_in;
      tag_ff    <= tag_in;
      tag_ok_ff <= tag_ok_in;
      if (pending_ff) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
         found_ff   <= found_in;
         idle_ff    <= idle_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.granted_tag = granted_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.all_idle    = idle_ff;

   // The fill count never goes past the pool size.
   `TTP_ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, stack_count <= CW'(POOL_SIZE))
   // Every accepted transaction waits in the request stage for the memory read, then lands
   // in the response register.
   `TTP_ASSERT_NEXT(a_accept_to_rsp, clock, reset, req_accept, pending_ff ##1 rsp_valid_ff)
   // A successful free puts exactly one tag back on the stack.
   `TTP_ASSERT_NEXT(a_free_push, clock, reset, ok_free, stack_count == CW'($past(stack_count) + 1'b1))

endmodule

`default_nettype wire

// ===== tb/tag_pool_checker.sv =====
// Checker for the transaction tag pool: watches both channels, predicts each result.
// Depends on ttp_pkg and the ttp_req_if / ttp_rsp_if interfaces.
`default_nettype none

module tag_pool_checker #(
   parameter int POOL_SIZE = ttp_pkg::POOL_SIZE_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ttp_req_if        req_mon,
   ttp_rsp_if        rsp_mon,
   output int        mismatch_total,
   output int        results_outstanding
);
   import ttp_pkg::*;

   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [1:0]       status;
      logic [TAG_W-1:0] granted_tag;
      logic             found;
      logic             all_idle;
   } tag_result_t;

   // Shadow copy of the pool: free-tag stack, its depth and one busy bit per tag.
   logic [TAG_W-1:0] free_tags [POOL_SIZE];
   int               free_depth;
   logic [POOL_SIZE:0] busy_tags;

   tag_result_t pending_tag_results [$];
   int          mismatches = 0;
   int          pending_count = 0;
   int          rsp_seen = 0;

   assign mismatch_total      = mismatches;
   assign results_outstanding = pending_count;

   // Reset state: tag 1 on top of the stack, every tag idle.
   task automatic clear_pool_model();
      for (int k = 0; k < POOL_SIZE; k++) begin
         free_tags[k] = TAG_W'(POOL_SIZE - k);
      end
      free_depth = POOL_SIZE;
      busy_tags  = '0;
   endtask

   // Applies one request to the shadow pool and returns the result it should produce.
   function automatic tag_result_t predict_tag_result(input logic [1:0] kind,
                                                      input logic wait_empty,
                                                      input logic [TAG_W-1:0] tag);
      tag_result_t r;
      logic        hit;
      r   = '0;
      hit = 1'b0;
      if (tag != '0 && int'(tag) <= POOL_SIZE) begin
         hit = busy_tags[tag];
      end
      case (kind)
         KIND_ALLOC: begin
            if (wait_empty && free_depth != POOL_SIZE) begin
               r.status = ST_WAIT;
            end else if (free_depth == 0) begin
               r.status = ST_EXHAUSTED;
            end else begin
               free_depth    = free_depth - 1;
               r.granted_tag = free_tags[free_depth];
               busy_tags[r.granted_tag] = 1'b1;
            end
         end
         KIND_LOOKUP: begin
            if (hit) begin
               r.found = 1'b1;
            end else begin
               r.status = ST_NOT_OUT;
            end
         end
         KIND_FREE: begin
            if (hit && free_depth < POOL_SIZE) begin
               busy_tags[tag]        = 1'b0;
               free_tags[free_depth] = tag;
               free_depth            = free_depth + 1;
            end else begin
               r.status = ST_NOT_OUT;
            end
         end
         default: begin
            // The unused kind leaves the pool alone and answers ok.
         end
      endcase
      r.all_idle = (free_depth == POOL_SIZE);
      return r;
   endfunction

   // Prints one line per wrong field, for the first MAX_PRINTED, and counts every one.
   task automatic report_mismatch(input string what);
      if (mismatches < MAX_PRINTED) begin
         $display("tag pool mismatch at %0t, response %0d: %s", $realtime, rsp_seen, what);
      end
      mismatches = mismatches + 1;
   endtask

   // Results are compared before the request of the same edge is predicted,
   // since a response can never belong to a transaction accepted at that edge.
   always @(posedge clock) begin : track_pool
      tag_result_t got;
      tag_result_t want;
      if (reset) begin
         clear_pool_model();
         pending_tag_results.delete();
         pending_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            rsp_seen++;
            got.status      = rsp_mon.status;
            got.granted_tag = rsp_mon.granted_tag;
            got.found       = rsp_mon.found;
            got.all_idle    = rsp_mon.all_idle;
            if (pending_tag_results.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = pending_tag_results.pop_front();
               if (got.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
               end
               if (got.granted_tag !== want.granted_tag) begin
                  report_mismatch($sformatf("granted_tag %0d, expected %0d",
                                            got.granted_tag, want.granted_tag));
               end
               if (got.found !== want.found) begin
                  report_mismatch($sformatf("found %b, expected %b", got.found, want.found));
               end
               if (got.all_idle !== want.all_idle) begin
                  report_mismatch($sformatf("all_idle %b, expected %b",
                                            got.all_idle, want.all_idle));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_tag_results.push_back(
               predict_tag_result(req_mon.kind, req_mon.wait_empty, req_mon.tag));
         end
         pending_count <= pending_tag_results.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the transaction tag pool testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on ttp_pkg, the channel interfaces, transaction_tag_pool and tag_pool_checker.
`default_nettype none

module testbench;
   import ttp_pkg::*;

   localparam int POOL_SIZE      = POOL_SIZE_DEF;
   localparam int HALF_PERIOD    = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int PHASE_ITEMS    = 125;
   localparam int DRAIN_CYCLES   = 10;

   // Kind code that the block does not use.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   results_outstanding;
   int   idle_cycles = 0;
   int   send_idle_mode = 0;
   int   rsp_idle_mode = 0;
   bit   want_long_hold = 1'b0;
   bit   long_hold_done = 1'b0;

   ttp_req_if req_bus ();
   ttp_rsp_if rsp_bus ();

   transaction_tag_pool #(.POOL_SIZE(POOL_SIZE)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tag_pool_checker #(.POOL_SIZE(POOL_SIZE)) i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_bus),
      .rsp_mon             (rsp_bus),
      .mismatch_total      (mismatches),
      .results_outstanding (results_outstanding)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Idle length: none in mode 0, otherwise mostly short with a few long gaps.
   function automatic int pick_idle(input int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0 || r < 55) begin
         return 0;
      end else if (r < 88) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Offers one transaction after a random gap and returns once it is accepted.
   task automatic send_request(input logic [1:0] kind, input logic wait_empty,
                               input logic [TAG_W-1:0] tag);
      int gap;
      gap = pick_idle(send_idle_mode);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.wait_empty <= wait_empty;
      req_bus.tag        <= tag;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stops offering and waits until every predicted result has been received.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (results_outstanding != 0);
   endtask

   // Response side: random stalls, and one long hold-off when asked for.
   initial begin : rsp_side
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (want_long_hold && !long_hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            stall = pick_idle(rsp_idle_mode);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run when no request is accepted and no response taken for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed corner cases, then phases of random transactions.
   initial begin : stimulus
      int alloc_pct;
      int pick;
      int mix [3];
      mix = '{50, 85, 15};
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_ALLOC;
      req_bus.wait_empty <= 1'b0;
      req_bus.tag        <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Misses on an idle pool, the unused kind, and wait-for-idle both ways.
      send_request(KIND_LOOKUP, 1'b0, 8'h00);
      send_request(KIND_LOOKUP, 1'b1, 8'hFF);
      send_request(KIND_FREE, 1'b0, 8'd1);
      send_request(KIND_UNUSED, 1'b1, 8'hAA);
      send_request(KIND_ALLOC, 1'b1, 8'h55);
      send_request(KIND_ALLOC, 1'b1, 8'h00);
      send_request(KIND_LOOKUP, 1'b0, 8'd1);
      send_request(KIND_LOOKUP, 1'b0, TAG_W'(POOL_SIZE + 1));
      send_request(KIND_FREE, 1'b0, 8'h00);
      send_request(KIND_FREE, 1'b0, TAG_W'(POOL_SIZE + 1));
      send_request(KIND_FREE, 1'b0, TAG_W'(POOL_SIZE));

      // Run the pool dry, including one allocate on an empty pool.
      for (int k = 1; k <= POOL_SIZE; k++) begin
         send_request(KIND_ALLOC, 1'b0, 8'h00);
      end

      // Freed tags come back last in, first out.
      send_request(KIND_FREE, 1'b0, TAG_W'(POOL_SIZE));
      send_request(KIND_FREE, 1'b0, 8'd5);
      send_request(KIND_ALLOC, 1'b0, 8'h00);

      // Random phases cycle through a balanced, a filling and an emptying mix.
      for (int phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
         alloc_pct      = mix[phase % 3];
         send_idle_mode = (phase % 4 == 1) ? 0 : 1;
         rsp_idle_mode  = (phase % 5 == 2) ? 0 : 1;
         if (phase == 3) begin
            want_long_hold = 1'b1;
         end
         if (phase == 7) begin
            drain_results();
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               // Noise: any kind and any tag.
               send_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            TAG_W'($urandom_range(0, 255)));
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < alloc_pct) begin
                  send_request(KIND_ALLOC, ($urandom_range(0, 3) == 0),
                               TAG_W'($urandom_range(0, 255)));
               end else if (pick < alloc_pct + (100 - alloc_pct) / 3) begin
                  send_request(KIND_LOOKUP, 1'($urandom_range(0, 1)),
                               TAG_W'($urandom_range(1, POOL_SIZE)));
               end else begin
                  send_request(KIND_FREE, 1'($urandom_range(0, 1)),
                               TAG_W'($urandom_range(1, POOL_SIZE)));
               end
            end
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
